// ===== hw/rtl/cif_pkg.sv =====
// ---------------------------------------------------------------------------
// Curve intersection finder package
// Shared sizes, request codes, register indexes, types and helpers.
// ---------------------------------------------------------------------------
package cif_pkg;

    localparam int MAX_CURVES = 8;
    localparam int MAX_POINTS = 64;
    localparam int MAX_HITS   = 64;

    localparam int CW   = $clog2(MAX_CURVES);
    localparam int PW   = $clog2(MAX_POINTS);
    localparam int HW   = $clog2(MAX_HITS);
    localparam int LW   = PW + 1;
    localparam int CNTW = HW + 1;
    localparam int SW   = PW + 2;

    // Request codes.
    localparam logic [2:0] REQ_ROT_PT  = 3'd0;
    localparam logic [2:0] REQ_EFF_PT  = 3'd1;
    localparam logic [2:0] REQ_ROT_LAB = 3'd2;
    localparam logic [2:0] REQ_EFF_LAB = 3'd3;
    localparam logic [2:0] REQ_START   = 3'd4;

    // Register indexes (word offsets on the configuration port).
    localparam logic [2:0] REG_ROT_CNT = 3'd0;
    localparam logic [2:0] REG_EFF_CNT = 3'd1;
    localparam logic [2:0] REG_X_TOL   = 3'd2;
    localparam logic [2:0] REG_Y_TOL   = 3'd3;
    localparam logic [2:0] REG_M_TOL   = 3'd4;

    typedef struct packed {
        logic [15:0]   x;
        logic [15:0]   y;
        logic [CW-1:0] rot;
        logic [CW-1:0] eff;
    } t_hit;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_PAIR,
        ST_NEXT_PAIR,
        ST_YR_A,
        ST_YR_B,
        ST_EP_CHK,
        ST_EP_A,
        ST_EP_B,
        ST_BS_A,
        ST_BS_B,
        ST_MG_CHK,
        ST_MG_A,
        ST_MG_B,
        ST_SORT,
        ST_MIN,
        ST_SC_A,
        ST_SC_B,
        ST_SC_NEXT,
        ST_EMIT
    } t_state;

    // True when two coordinates differ by no more than the tolerance.
    function automatic logic near_enough(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] tol);
        logic [15:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return d <= tol;
    endfunction

endpackage

// ===== hw/rtl/cif_req_if.sv =====
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries load and start items into the finder.
// ---------------------------------------------------------------------------
interface cif_req_if;
    import cif_pkg::*;

    logic            valid;
    logic            ready;
    logic [2:0]      req_type;
    logic [2:0]      curve_index;
    logic [5:0]      point_index;
    logic [15:0]     point_x;
    logic [15:0]     point_y;
    logic [31:0]     curve_label;
    logic            final_point;

    modport source(output valid, req_type, curve_index, point_index, point_x, point_y,
                   curve_label, final_point, input ready);
    modport sink(input valid, req_type, curve_index, point_index, point_x, point_y,
                 curve_label, final_point, output ready);
endinterface

// ===== hw/rtl/cif_hit_if.sv =====
// ---------------------------------------------------------------------------
// Hit channel
// Valid/ready channel that carries sorted intersection results.
// ---------------------------------------------------------------------------
interface cif_hit_if;
    import cif_pkg::*;

    logic        valid;
    logic        ready;
    logic [31:0] hit_rotation_label;
    logic [31:0] hit_efficiency_label;
    logic [15:0] hit_x;
    logic [15:0] hit_y;
    logic        hit_valid;
    logic        table_overflowed;
    logic        last_result;

    modport source(output valid, hit_rotation_label, hit_efficiency_label, hit_x, hit_y,
                   hit_valid, table_overflowed, last_result, input ready);
    modport sink(input valid, hit_rotation_label, hit_efficiency_label, hit_x, hit_y,
                 hit_valid, table_overflowed, last_result, output ready);
endinterface

// ===== hw/rtl/curve_intersection_finder.sv =====
// ---------------------------------------------------------------------------
// Curve intersection finder
// Load items are accepted while idle. A start item takes each curve pair in turn:
// a y range scan of the rotation curve, a range check per efficiency point, a binary
// search on x and a compare against each stored hit; then the hits are sorted by
// rotation label and sent, each result held until the hit channel is ready.
// Synchronous active-low reset restores control and configuration registers, clears lengths, labels, hit count.
// ---------------------------------------------------------------------------
module curve_intersection_finder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cif_req_if.sink      i_req,
    cif_hit_if.source    o_hit,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cif_pkg::*;

    localparam int NPT = MAX_CURVES * MAX_POINTS;
    localparam int NHT = 2 * MAX_HITS;

    // Configuration registers.
    logic [3:0]  r_rot_cnt, r_eff_cnt;
    logic [15:0] r_x_tol, r_y_tol, r_m_tol;

    // Stores.
    logic [31:0]   rot_mem [NPT];
    logic [31:0]   eff_mem [NPT];
    t_hit          hit_mem [NHT];
    logic [31:0]   r_rot_q, r_eff_q;
    t_hit          r_hit_q;
    logic [LW-1:0] r_rlen [MAX_CURVES];
    logic [LW-1:0] r_elen [MAX_CURVES];
    logic [31:0]   r_rlab [MAX_CURVES];
    logic [31:0]   r_elab [MAX_CURVES];

    // Sequencer state.
    t_state          r_state, n_state;
    logic [CW-1:0]   r_i, n_i, r_k, n_k;
    logic [LW-1:0]   r_j, n_j;
    logic [15:0]     r_ymin, n_ymin, r_ymax, n_ymax, r_px, n_px, r_py, n_py;
    logic signed [SW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [CNTW-1:0] r_n, n_n, r_wr, n_wr, r_cnt, n_cnt;
    logic            r_bank, n_bank, r_ovf, n_ovf, r_have, n_have, r_first, n_first;
    logic [31:0]     r_best, n_best, r_prev, n_prev;

    // Output registers.
    logic [31:0] r_o_rlab, n_o_rlab, r_o_elab, n_o_elab;
    logic [15:0] r_o_x, n_o_x, r_o_y, n_o_y;
    logic        r_o_hv, n_o_hv, r_o_last, n_o_last;

    // Shared combinational terms.
    logic            accept;
    logic [3:0]      rc_sat, ec_sat;
    logic [LW-1:0]   cur_rlen, cur_elen;
    logic signed [SW-1:0] mid, lo_up, hi_dn;
    logic [PW-1:0]   rot_raddr_p;
    logic [HW-1:0]   hit_raddr_n;
    logic            x_near, y_near, in_range, bs_stop, mg_near, label_new, label_better;
    logic            hit_full;
    logic [CW-1:0]   lab_addr;
    logic [31:0]     lab_val;
    logic [16:0]     sum_x, sum_y;
    logic            hw_en;
    logic [HW:0]     hw_addr;
    t_hit            hw_data;
    logic            cfg_we;

    assign accept   = i_req.valid && i_req.ready;
    assign rc_sat   = (r_rot_cnt > 4'(MAX_CURVES)) ? 4'(MAX_CURVES) : r_rot_cnt;
    assign ec_sat   = (r_eff_cnt > 4'(MAX_CURVES)) ? 4'(MAX_CURVES) : r_eff_cnt;
    assign cur_rlen = r_rlen[r_k];
    assign cur_elen = r_elen[r_i];

    // Binary search step: midpoint and the two possible bounds.
    assign mid   = (r_lo + r_hi) >>> 1;
    assign lo_up = mid + SW'(1);
    assign hi_dn = mid - SW'(1);
    assign x_near = near_enough(r_px, r_rot_q[31:16], r_x_tol);
    assign y_near = near_enough(r_py, r_rot_q[15:0], r_y_tol);
    assign bs_stop = (r_px > r_rot_q[31:16]) ? (lo_up > r_hi) : (r_lo > hi_dn);
    assign in_range = !((r_eff_q[15:0] < r_ymin) || (r_eff_q[15:0] > r_ymax));

    assign rot_raddr_p = (r_state == ST_BS_A) ? mid[PW-1:0] : r_j[PW-1:0];
    assign hit_raddr_n = r_n[HW-1:0];

    // Merge test and averaging against a stored hit.
    assign mg_near = near_enough(r_px, r_hit_q.x, r_m_tol) &&
                     near_enough(r_py, r_hit_q.y, r_m_tol);
    assign sum_x = {1'b0, r_px} + {1'b0, r_hit_q.x};
    assign sum_y = {1'b0, r_py} + {1'b0, r_hit_q.y};
    assign hit_full = r_cnt >= CNTW'(MAX_HITS);

    // One rotation label read port, shared by the minimum search and the scan.
    assign lab_addr = (r_state == ST_SC_B) ? r_hit_q.rot : r_k;
    assign lab_val  = r_rlab[lab_addr];
    assign label_new    = r_first || (lab_val > r_prev);
    assign label_better = !r_have || (lab_val < r_best);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req.req_type == REQ_START) n_state = ST_START;
            end
            ST_START: begin
                n_state = (rc_sat == 4'd0 || ec_sat == 4'd0) ? ST_SORT : ST_PAIR;
            end
            ST_PAIR: begin
                n_state = (cur_rlen == '0) ? ST_NEXT_PAIR : ST_YR_A;
            end
            ST_NEXT_PAIR: begin
                if (4'(r_k) + 4'd1 < rc_sat || 4'(r_i) + 4'd1 < ec_sat) n_state = ST_PAIR;
                else n_state = ST_SORT;
            end
            ST_YR_A: n_state = ST_YR_B;
            ST_YR_B: begin
                n_state = (r_j + LW'(1) == cur_rlen) ? ST_EP_CHK : ST_YR_A;
            end
            ST_EP_CHK: begin
                n_state = (r_j >= cur_elen) ? ST_NEXT_PAIR : ST_EP_A;
            end
            ST_EP_A: n_state = ST_EP_B;
            ST_EP_B: begin
                n_state = in_range ? ST_BS_A : ST_EP_CHK;
            end
            ST_BS_A: n_state = ST_BS_B;
            ST_BS_B: begin
                if (x_near) n_state = y_near ? ST_MG_CHK : ST_EP_CHK;
                else n_state = bs_stop ? ST_EP_CHK : ST_BS_A;
            end
            ST_MG_CHK: begin
                n_state = (r_n >= r_cnt) ? ST_EP_CHK : ST_MG_A;
            end
            ST_MG_A: n_state = ST_MG_B;
            ST_MG_B: begin
                n_state = mg_near ? ST_EP_CHK : ST_MG_CHK;
            end
            ST_SORT: begin
                n_state = (r_cnt == '0) ? ST_EMIT : ST_MIN;
            end
            ST_MIN: begin
                if (r_k == CW'(MAX_CURVES - 1)) n_state = ST_SC_A;
            end
            ST_SC_A: n_state = ST_SC_B;
            ST_SC_B: begin
                n_state = (lab_val == r_prev) ? ST_EMIT : ST_SC_NEXT;
            end
            ST_SC_NEXT: begin
                n_state = (r_n + CNTW'(1) == r_cnt) ? ST_MIN : ST_SC_A;
            end
            ST_EMIT: begin
                if (o_hit.ready) n_state = r_o_last ? ST_IDLE : ST_SC_NEXT;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath next values and hit table writes.
    always_comb begin
        n_i = r_i;  n_k = r_k;  n_j = r_j;
        n_ymin = r_ymin;  n_ymax = r_ymax;  n_px = r_px;  n_py = r_py;
        n_lo = r_lo;  n_hi = r_hi;  n_n = r_n;  n_wr = r_wr;  n_cnt = r_cnt;
        n_bank = r_bank;  n_ovf = r_ovf;  n_have = r_have;  n_first = r_first;
        n_best = r_best;  n_prev = r_prev;
        n_o_rlab = r_o_rlab;  n_o_elab = r_o_elab;  n_o_x = r_o_x;  n_o_y = r_o_y;
        n_o_hv = r_o_hv;  n_o_last = r_o_last;
        hw_en = 1'b0;
        hw_addr = {r_bank, r_n[HW-1:0]};
        hw_data = r_hit_q;
        case (r_state)
            ST_START: begin
                n_ovf = 1'b0;  n_i = '0;  n_k = '0;
            end
            ST_PAIR: begin
                n_ymin = 16'hFFFF;  n_ymax = '0;  n_j = '0;
            end
            ST_NEXT_PAIR: begin
                if (4'(r_k) + 4'd1 < rc_sat) begin
                    n_k = r_k + CW'(1);
                end else if (4'(r_i) + 4'd1 < ec_sat) begin
                    n_k = '0;
                    n_i = r_i + CW'(1);
                end
            end
            ST_YR_B: begin
                if (r_rot_q[15:0] > r_ymax) n_ymax = r_rot_q[15:0];
                if (r_rot_q[15:0] < r_ymin) n_ymin = r_rot_q[15:0];
                n_j = (r_j + LW'(1) == cur_rlen) ? '0 : r_j + LW'(1);
            end
            ST_EP_B: begin
                n_px = r_eff_q[31:16];
                n_py = r_eff_q[15:0];
                n_lo = '0;
                n_hi = SW'(cur_rlen) - SW'(1);
                if (!in_range) n_j = r_j + LW'(1);
            end
            ST_BS_B: begin
                if (x_near) begin
                    n_n = '0;
                    if (!y_near) n_j = r_j + LW'(1);
                end else begin
                    if (r_px > r_rot_q[31:16]) n_lo = lo_up;
                    else n_hi = hi_dn;
                    if (bs_stop) n_j = r_j + LW'(1);
                end
            end
            ST_MG_CHK: begin
                if (r_n >= r_cnt) begin
                    n_j = r_j + LW'(1);
                    if (hit_full) begin
                        n_ovf = 1'b1;
                    end else begin
                        hw_en = 1'b1;
                        hw_addr = {r_bank, r_cnt[HW-1:0]};
                        hw_data = '{x: r_px, y: r_py, rot: r_k, eff: r_i};
                        n_cnt = r_cnt + CNTW'(1);
                    end
                end
            end
            ST_MG_B: begin
                if (mg_near) begin
                    hw_en = 1'b1;
                    hw_data.x = sum_x[16:1];
                    hw_data.y = sum_y[16:1];
                    n_j = r_j + LW'(1);
                end else begin
                    n_n = r_n + CNTW'(1);
                end
            end
            ST_SORT: begin
                n_k = '0;  n_have = 1'b0;  n_first = 1'b1;  n_wr = '0;
                if (r_cnt == '0) begin
                    n_o_rlab = '0;  n_o_elab = '0;  n_o_x = '0;  n_o_y = '0;
                    n_o_hv = 1'b0;  n_o_last = 1'b1;
                end
            end
            ST_MIN: begin
                if (label_new && label_better) begin
                    n_best = lab_val;
                    n_have = 1'b1;
                end
                if (r_k == CW'(MAX_CURVES - 1)) begin
                    n_prev  = (label_new && label_better) ? lab_val : r_best;
                    n_first = 1'b0;
                    n_n     = '0;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            ST_SC_B: begin
                if (lab_val == r_prev) begin
                    hw_en = 1'b1;
                    hw_addr = {~r_bank, r_wr[HW-1:0]};
                    n_wr = r_wr + CNTW'(1);
                    n_o_rlab = lab_val;
                    n_o_elab = r_elab[r_hit_q.eff];
                    n_o_x = r_hit_q.x;
                    n_o_y = r_hit_q.y;
                    n_o_hv = 1'b1;
                    n_o_last = (r_wr + CNTW'(1) == r_cnt);
                end
            end
            ST_SC_NEXT: begin
                if (r_n + CNTW'(1) == r_cnt) begin
                    n_k = '0;
                    n_have = 1'b0;
                end else begin
                    n_n = r_n + CNTW'(1);
                end
            end
            ST_EMIT: begin
                if (o_hit.ready && r_o_last) n_bank = ~r_bank;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_bank  <= 1'b0;
            r_ovf   <= 1'b0;
            r_have  <= 1'b0;
            r_first <= 1'b1;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_bank  <= n_bank;
            r_ovf   <= n_ovf;
            r_have  <= n_have;
            r_first <= n_first;
        end
    end

    // Sequencer payload registers.
    always_ff @(posedge i_clk) begin
        r_i <= n_i;  r_k <= n_k;  r_j <= n_j;
        r_ymin <= n_ymin;  r_ymax <= n_ymax;  r_px <= n_px;  r_py <= n_py;
        r_lo <= n_lo;  r_hi <= n_hi;  r_n <= n_n;  r_wr <= n_wr;
        r_best <= n_best;  r_prev <= n_prev;
        r_o_rlab <= n_o_rlab;  r_o_elab <= n_o_elab;
        r_o_x <= n_o_x;  r_o_y <= n_o_y;  r_o_hv <= n_o_hv;  r_o_last <= n_o_last;
    end

    // Point stores: written by load transfers, read with a registered port.
    always_ff @(posedge i_clk) begin
        if (accept && i_req.req_type == REQ_ROT_PT)
            rot_mem[{i_req.curve_index, i_req.point_index}] <= {i_req.point_x, i_req.point_y};
        r_rot_q <= rot_mem[{r_k, rot_raddr_p}];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_req.req_type == REQ_EFF_PT)
            eff_mem[{i_req.curve_index, i_req.point_index}] <= {i_req.point_x, i_req.point_y};
        r_eff_q <= eff_mem[{r_i, r_j[PW-1:0]}];
    end

    // Hit table, two banks: sorting copies the live bank into the other one.
    always_ff @(posedge i_clk) begin
        if (hw_en) hit_mem[hw_addr] <= hw_data;
        r_hit_q <= hit_mem[{r_bank, hit_raddr_n}];
    end

    // Curve lengths and labels.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CURVES; c++) begin
                r_rlen[c] <= '0;
                r_elen[c] <= '0;
                r_rlab[c] <= '0;
                r_elab[c] <= '0;
            end
        end else if (accept) begin
            case (i_req.req_type)
                REQ_ROT_PT: begin
                    if (i_req.final_point)
                        r_rlen[i_req.curve_index] <= LW'(i_req.point_index) + LW'(1);
                end
                REQ_EFF_PT: begin
                    if (i_req.final_point)
                        r_elen[i_req.curve_index] <= LW'(i_req.point_index) + LW'(1);
                end
                REQ_ROT_LAB: r_rlab[i_req.curve_index] <= i_req.curve_label;
                REQ_EFF_LAB: r_elab[i_req.curve_index] <= i_req.curve_label;
                default: ;
            endcase
        end
    end

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_cnt <= '0;
            r_eff_cnt <= '0;
            r_x_tol   <= 16'd40;
            r_y_tol   <= 16'd72;
            r_m_tol   <= 16'd112;
        end else if (cfg_we) begin
            case (paddr[4:2])
                REG_ROT_CNT: r_rot_cnt <= pwdata[3:0];
                REG_EFF_CNT: r_eff_cnt <= pwdata[3:0];
                REG_X_TOL:   r_x_tol   <= pwdata[15:0];
                REG_Y_TOL:   r_y_tol   <= pwdata[15:0];
                REG_M_TOL:   r_m_tol   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ROT_CNT: prdata = {28'd0, r_rot_cnt};
            REG_EFF_CNT: prdata = {28'd0, r_eff_cnt};
            REG_X_TOL:   prdata = {16'd0, r_x_tol};
            REG_Y_TOL:   prdata = {16'd0, r_y_tol};
            REG_M_TOL:   prdata = {16'd0, r_m_tol};
            default:     prdata = '0;
        endcase
    end

    // Channel outputs.
    assign i_req.ready                = (r_state == ST_IDLE);
    assign o_hit.valid                = (r_state == ST_EMIT);
    assign o_hit.hit_rotation_label   = r_o_rlab;
    assign o_hit.hit_efficiency_label = r_o_elab;
    assign o_hit.hit_x                = r_o_x;
    assign o_hit.hit_y                = r_o_y;
    assign o_hit.hit_valid            = r_o_hv;
    assign o_hit.table_overflowed     = r_ovf;
    assign o_hit.last_result          = r_o_last;

endmodule
